@@ design/bfa_pkg.sv @@
package bfa_pkg;

    // stream payload layout
    localparam int IN_DATA_W     = 16;
    localparam int OUT_DATA_W    = 24;
    localparam int FRAME_FIELD_W = 12;

    // input tdata bit positions
    localparam int IN_KERNEL_BIT = 12;
    localparam int IN_WRITE_BIT  = 13;

    // output tdata bit positions
    localparam int OUT_PRESENT_BIT = 12;
    localparam int OUT_WRITE_BIT   = 13;
    localparam int OUT_USER_BIT    = 14;
    localparam int OUT_UPDATED_BIT = 15;
    localparam int OUT_OOF_BIT     = 16;

    // action codes carried on tuser
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_ALLOC_WR,
        ST_DIV_EST,
        ST_DIV_FIX,
        ST_FREE_RD,
        ST_FREE_WR,
        ST_FINISH
    } t_state;

    // what the finished result looks like
    typedef enum logic [2:0] {
        RES_NONE,
        RES_KEEP,
        RES_ALLOC,
        RES_FREE,
        RES_OOF
    } t_res;

    typedef struct packed {
        logic capture_in;
        logic scan_start;
        logic scan_run;
        logic alloc_write;
        logic div_est;
        logic div_fix;
        logic free_read;
        logic free_write;
        logic load_out;
        t_res kind;
    } t_cmd;

    typedef struct packed {
        logic is_free;
        logic cur_zero;
        logic scan_hit;
        logic scan_end;
        logic bitmap_full;
        logic slot_free;
    } t_status;

endpackage

@@ design/bfa_ctrl.sv @@
module bfa_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  bfa_pkg::t_status i_status,
    output bfa_pkg::t_cmd    o_cmd
);
    import bfa_pkg::*;

    t_state r_state, n_state;
    t_res   r_kind, n_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_kind  <= RES_NONE;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_kind     = r_kind;
        o_cmd      = '0;
        o_cmd.kind = r_kind;
        o_s_tready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.capture_in = 1'b1;
                    n_state          = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (i_status.is_free) begin
                    if (i_status.cur_zero) begin
                        n_kind  = RES_NONE;
                        n_state = ST_FINISH;
                    end else begin
                        n_state = ST_DIV_EST;
                    end
                end else if (!i_status.cur_zero) begin
                    n_kind  = RES_KEEP;
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan_run = 1'b1;
                if (i_status.scan_hit) begin
                    n_state = ST_ALLOC_WR;
                end else if (i_status.scan_end) begin
                    if (i_status.bitmap_full) begin
                        n_kind  = RES_OOF;
                        n_state = ST_FINISH;
                    end else begin
                        n_state = ST_ALLOC_WR;
                    end
                end
            end
            ST_ALLOC_WR: begin
                o_cmd.alloc_write = 1'b1;
                n_kind            = RES_ALLOC;
                n_state           = ST_FINISH;
            end
            ST_DIV_EST: begin
                o_cmd.div_est = 1'b1;
                n_state       = ST_DIV_FIX;
            end
            ST_DIV_FIX: begin
                o_cmd.div_fix = 1'b1;
                n_state       = ST_FREE_RD;
            end
            ST_FREE_RD: begin
                o_cmd.free_read = 1'b1;
                n_state         = ST_FREE_WR;
            end
            ST_FREE_WR: begin
                o_cmd.free_write = 1'b1;
                n_kind           = RES_FREE;
                n_state          = ST_FINISH;
            end
            ST_FINISH: begin
                if (i_status.slot_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

@@ design/bfa_datapath.sv @@
module bfa_datapath #(
    parameter int NUM_FRAMES = 4096,
    parameter int WORD_BITS  = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [bfa_pkg::IN_DATA_W-1:0]      i_s_tdata,
    input  logic                               i_s_tuser,
    input  bfa_pkg::t_cmd                      i_cmd,
    output bfa_pkg::t_status                   o_status,
    input  logic                               i_m_tready,
    output logic                               o_m_tvalid,
    output logic [bfa_pkg::OUT_DATA_W-1:0]     o_m_tdata
);
    import bfa_pkg::*;

    localparam int NUM_WORDS = NUM_FRAMES / WORD_BITS;
    localparam int IDX_W     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int CNT_W     = $clog2(NUM_WORDS + 1);
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int FRAME_W   = $clog2(NUM_FRAMES);
    localparam int EXT_W     = (FRAME_W > FRAME_FIELD_W) ? FRAME_W : FRAME_FIELD_W;
    localparam int CMP_W     = (CNT_W > FRAME_FIELD_W) ? CNT_W : FRAME_FIELD_W;
    // reciprocal divide of a 12-bit frame by the word size, off by at most one
    localparam int K_SH      = FRAME_FIELD_W + BIT_W;
    localparam int M_W       = FRAME_FIELD_W + BIT_W;
    localparam int P_W       = FRAME_FIELD_W + M_W;
    localparam int RECIP     = (2 ** K_SH) / WORD_BITS;

    logic [WORD_BITS-1:0] mem [NUM_WORDS];

    // captured item
    logic                     r_action;
    logic [FRAME_FIELD_W-1:0] r_cur;
    logic                     r_kernel;
    logic                     r_write;

    // scan and fill tracking
    logic [CNT_W-1:0]     r_hwm;
    logic [CNT_W-1:0]     r_rd_idx;
    logic                 r_chk_vld;
    logic [IDX_W-1:0]     r_chk_idx;
    logic [WORD_BITS-1:0] r_rdata;

    logic [IDX_W-1:0]     r_win_idx;
    logic [BIT_W-1:0]     r_win_bit;
    logic [WORD_BITS-1:0] r_win_word;
    logic [FRAME_W-1:0]   r_frame;

    logic [FRAME_FIELD_W-1:0] r_q;
    logic [BIT_W-1:0]         r_b;

    logic                     r_out_vld;
    logic [OUT_DATA_W-1:0]    r_out_data;

    logic                     rd_issue;
    logic                     rd_en;
    logic [IDX_W-1:0]         rd_addr;
    logic                     wr_en;
    logic [IDX_W-1:0]         wr_addr;
    logic [WORD_BITS-1:0]     wr_data;
    logic                     q_in;
    logic                     scan_hit;
    logic                     scan_end;
    logic [BIT_W-1:0]         fbit;
    logic [P_W-1:0]           est_prod;
    logic [FRAME_FIELD_W-1:0] rem;
    logic [FRAME_W-1:0]       frame_sum;
    logic [EXT_W-1:0]         frame_ext;
    logic [OUT_DATA_W-1:0]    n_out_data;

    assign rd_issue = i_cmd.scan_run && (r_rd_idx < r_hwm);
    assign q_in     = CMP_W'(r_q) < CMP_W'(r_hwm);
    assign scan_hit = r_chk_vld && (r_rdata != '1);
    assign scan_end = !r_chk_vld && (r_rd_idx == r_hwm);

    always_comb begin
        fbit = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!r_rdata[i]) begin
                fbit = BIT_W'(i);
            end
        end
    end

    assign rd_en   = rd_issue || (i_cmd.free_read && q_in);
    assign rd_addr = i_cmd.free_read ? r_q[IDX_W-1:0] : r_rd_idx[IDX_W-1:0];
    assign wr_en   = i_cmd.alloc_write || (i_cmd.free_write && q_in);
    assign wr_addr = i_cmd.alloc_write ? r_win_idx : r_q[IDX_W-1:0];
    assign wr_data = i_cmd.alloc_write
                   ? (r_win_word | (WORD_BITS'(1) << r_win_bit))
                   : (r_rdata & ~(WORD_BITS'(1) << r_b));

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign est_prod  = P_W'(r_cur) * P_W'(M_W'(RECIP));
    assign rem       = r_cur - FRAME_FIELD_W'(r_q * FRAME_FIELD_W'(WORD_BITS));
    assign frame_sum = FRAME_W'(r_win_idx) * FRAME_W'(WORD_BITS) + FRAME_W'(r_win_bit);
    assign frame_ext = EXT_W'(r_frame);

    always_comb begin
        n_out_data = '0;
        case (i_cmd.kind)
            RES_KEEP: begin
                n_out_data[FRAME_FIELD_W-1:0] = r_cur;
            end
            RES_ALLOC: begin
                n_out_data[FRAME_FIELD_W-1:0] = frame_ext[FRAME_FIELD_W-1:0];
                n_out_data[OUT_PRESENT_BIT]   = 1'b1;
                n_out_data[OUT_WRITE_BIT]     = r_write;
                n_out_data[OUT_USER_BIT]      = !r_kernel;
                n_out_data[OUT_UPDATED_BIT]   = 1'b1;
            end
            RES_FREE: begin
                n_out_data[OUT_UPDATED_BIT] = 1'b1;
            end
            RES_OOF: begin
                n_out_data[OUT_OOF_BIT] = 1'b1;
            end
            default: begin
                n_out_data = '0;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hwm     <= '0;
            r_rd_idx  <= '0;
            r_chk_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.scan_start) begin
                r_rd_idx  <= '0;
                r_chk_vld <= 1'b0;
            end else if (i_cmd.scan_run) begin
                r_chk_vld <= rd_issue;
                if (rd_issue) begin
                    r_rd_idx <= r_rd_idx + CNT_W'(1);
                end
            end
            if (i_cmd.alloc_write && (CNT_W'(r_win_idx) == r_hwm)) begin
                r_hwm <= r_hwm + CNT_W'(1);
            end
            if (i_cmd.load_out) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture_in) begin
            r_action <= i_s_tuser;
            r_cur    <= i_s_tdata[FRAME_FIELD_W-1:0];
            r_kernel <= i_s_tdata[IN_KERNEL_BIT];
            r_write  <= i_s_tdata[IN_WRITE_BIT];
        end
        if (rd_issue) begin
            r_chk_idx <= r_rd_idx[IDX_W-1:0];
        end
        if (i_cmd.scan_run) begin
            if (scan_hit) begin
                r_win_idx  <= r_chk_idx;
                r_win_bit  <= fbit;
                r_win_word <= r_rdata;
            end else if (scan_end) begin
                // first word past the fill mark has never been written
                r_win_idx  <= r_hwm[IDX_W-1:0];
                r_win_bit  <= '0;
                r_win_word <= '0;
            end
        end
        if (i_cmd.alloc_write) begin
            r_frame <= frame_sum;
        end
        if (i_cmd.div_est) begin
            r_q <= est_prod[K_SH +: FRAME_FIELD_W];
        end
        if (i_cmd.div_fix) begin
            if (rem >= FRAME_FIELD_W'(WORD_BITS)) begin
                r_q <= r_q + FRAME_FIELD_W'(1);
                r_b <= BIT_W'(rem - FRAME_FIELD_W'(WORD_BITS));
            end else begin
                r_b <= BIT_W'(rem);
            end
        end
        if (i_cmd.load_out) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_status.is_free     = (r_action == ACT_FREE);
    assign o_status.cur_zero    = (r_cur == '0);
    assign o_status.scan_hit    = scan_hit;
    assign o_status.scan_end    = scan_end;
    assign o_status.bitmap_full = (r_hwm == CNT_W'(NUM_WORDS));
    assign o_status.slot_free   = !r_out_vld || i_m_tready;

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;

endmodule

@@ design/bitmap_frame_allocator.sv @@
// Channel  Dir  Signals                        Contents
// s        in   i_s_tvalid/o_s_tready          tuser: action; tdata: frame, kernel, writable
// m        out  o_m_tvalid/i_m_tready          tdata: frame, present, writable, user,
//                                              updated, out_of_frames
//
// One item at a time. An allocate for a page that already holds a frame, or a
// free of no frame, goes from decode straight to the finish step; a free first
// runs a two-step reciprocal divide, then a read-modify-write of one bitmap word.
// An allocate walks the bitmap RAM up to the fill mark and stops at the first
// word with a clear bit, one word per cycle as the single RAM read port allows.
// The next item is taken the cycle after its result is loaded.
// Reset (synchronous, active low) clears the control state and the fill mark:
// words at and past the mark read as all free, so no clearing pass runs.
// A result waiting on i_m_tready does not block the next accept; a second
// result waits in the finish step.
module bitmap_frame_allocator #(
    parameter int NUM_FRAMES = 4096,
    parameter int WORD_BITS  = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // [11:0] current_frame, [12] kernel page, [13] writable, [15:14] zero
    input  logic [bfa_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // [0] action: 0 allocate, 1 free
    input  logic                           i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // [11:0] new_frame, [12] present_bit, [13] writable_bit, [14] user_bit,
    // [15] updated, [16] out_of_frames, [23:17] zero
    output logic [bfa_pkg::OUT_DATA_W-1:0] o_m_tdata
);
    import bfa_pkg::*;

    t_cmd    cmd;
    t_status status;

    bfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    bfa_datapath #(
        .NUM_FRAMES (NUM_FRAMES),
        .WORD_BITS  (WORD_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

@@ design/bfa_checker.sv @@
module bfa_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_tvalid,
    input logic                           o_s_tready,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [bfa_pkg::OUT_DATA_W-1:0] o_m_tdata
);
    import bfa_pkg::*;

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

    // one item in flight: no accept in the cycle after an accept
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("back-to-back accept");

    // exhaustion reports frame 0 and no page bits
    a_oof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[OUT_OOF_BIT] |->
            (o_m_tdata[OUT_UPDATED_BIT:OUT_PRESENT_BIT] == 4'b0000) &&
            (o_m_tdata[FRAME_FIELD_W-1:0] == '0))
        else $error("out_of_frames with other fields set");

    // a present page is always an update, never an exhaustion
    a_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[OUT_PRESENT_BIT] |->
            o_m_tdata[OUT_UPDATED_BIT] && !o_m_tdata[OUT_OOF_BIT])
        else $error("present without update");

endmodule

bind bitmap_frame_allocator bfa_checker u_bfa_checker (.*);
